### sv/assert_macros.svh
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

### sv/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

	// byte length claimed by a lead byte; LEN_BAD also means nothing pending
	typedef enum logic [2:0] {
		LEN_BAD   = 3'd0,
		LEN_ONE   = 3'd1,
		LEN_TWO   = 3'd2,
		LEN_THREE = 3'd3,
		LEN_FOUR  = 3'd4
	} lead_len_t;

	localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [20:0] MAX_CP       = 21'h10FFFF;
	localparam logic [20:0] SURR_FIRST   = 21'h00D800;
	localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
	localparam logic [20:0] MIN_TWO      = 21'h000080;
	localparam logic [20:0] MIN_THREE    = 21'h000800;

	// one to two code units caused by a single byte
	typedef struct packed {
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        two;
		logic        text_end;
	} job_t;

endpackage

### sv/u8u16_front.sv
`timescale 1ns / 1ps

module u8u16_front import u8u16_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	output job_t       job,
	output logic       job_valid,
	output logic       idle
);

	logic [20:0] pv_q, pv_d;
	lead_len_t   exp_q, exp_d;
	logic [2:0]  taken_q, taken_d;

	lead_len_t   lead_len;
	logic [20:0] lead_bits;
	logic        lead_start;
	logic        lead_emit;
	logic [15:0] lead_unit;

	logic        pending;
	logic        cont;
	logic [20:0] acc_val;
	logic [2:0]  taken_nx;
	logic        seq_done;
	logic        bad;
	logic [20:0] off;

	// classify the byte as a lead
	always_comb begin
		priority if (!in_byte[7]) begin
			lead_len = LEN_ONE;
		end else if (in_byte[7:5] == 3'b110) begin
			lead_len = LEN_TWO;
		end else if (in_byte[7:4] == 4'b1110) begin
			lead_len = LEN_THREE;
		end else if (in_byte[7:3] == 5'b11110) begin
			lead_len = LEN_FOUR;
		end else begin
			lead_len = LEN_BAD;
		end
	end

	// payload bits of a multi-byte lead
	always_comb begin
		unique case (lead_len)
			LEN_TWO:   lead_bits = {16'd0, in_byte[4:0]};
			LEN_THREE: lead_bits = {17'd0, in_byte[3:0]};
			LEN_FOUR:  lead_bits = {18'd0, in_byte[2:0]};
			default:   lead_bits = '0;
		endcase
	end

	assign lead_start = (lead_len == LEN_TWO) || (lead_len == LEN_THREE) ||
		(lead_len == LEN_FOUR);
	assign lead_emit  = (lead_len == LEN_BAD) || (lead_len == LEN_ONE) ||
		(lead_start && text_end);
	assign lead_unit  = (lead_len == LEN_ONE) ? {8'h00, in_byte} : REPLACEMENT;

	// continuation path
	assign pending  = (exp_q != LEN_BAD);
	assign cont     = (in_byte[7:6] == 2'b10);
	assign acc_val  = {pv_q[14:0], in_byte[5:0]};
	assign taken_nx = taken_q + 3'd1;
	assign seq_done = (taken_nx >= exp_q);
	assign off      = acc_val - SUPP_BASE;

	// overlong, surrogate or out of range
	assign bad = ((exp_q == LEN_TWO) && (acc_val < MIN_TWO)) ||
		((exp_q == LEN_THREE) && (acc_val < MIN_THREE)) ||
		((exp_q == LEN_FOUR) && (acc_val < SUPP_BASE)) ||
		((acc_val >= SURR_FIRST) && (acc_val <= SURR_LAST)) ||
		(acc_val > MAX_CP);

	// build the job and the next decoder state
	always_comb begin
		job          = '0;
		job.text_end = text_end;
		job_valid    = 1'b0;
		pv_d         = pv_q;
		exp_d        = exp_q;
		taken_d      = taken_q;
		if (pending && cont) begin
			if (seq_done) begin
				job_valid = 1'b1;
				pv_d      = '0;
				exp_d     = LEN_BAD;
				taken_d   = '0;
				if (bad) begin
					job.unit0 = REPLACEMENT;
				end else if (acc_val < SUPP_BASE) begin
					job.unit0 = acc_val[15:0];
				end else begin
					job.unit0 = HI_SURR_BASE + {6'd0, off[19:10]};
					job.unit1 = LO_SURR_BASE + {6'd0, off[9:0]};
					job.two   = 1'b1;
				end
			end else if (text_end) begin
				job_valid = 1'b1;
				job.unit0 = REPLACEMENT;
				pv_d      = '0;
				exp_d     = LEN_BAD;
				taken_d   = '0;
			end else begin
				pv_d    = acc_val;
				taken_d = taken_nx;
			end
		end else begin
			// broken sequence first, then the byte as a new lead
			if (pending) begin
				job_valid = 1'b1;
				job.unit0 = REPLACEMENT;
			end
			pv_d    = '0;
			exp_d   = LEN_BAD;
			taken_d = '0;
			if (lead_start && !text_end) begin
				pv_d    = lead_bits;
				exp_d   = lead_len;
				taken_d = 3'd1;
			end
			if (lead_emit) begin
				job_valid = 1'b1;
				if (pending) begin
					job.unit1 = lead_unit;
					job.two   = 1'b1;
				end else begin
					job.unit0 = lead_unit;
				end
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= '0;
			exp_q   <= LEN_BAD;
			taken_q <= '0;
		end else if (accept) begin
			pv_q    <= pv_d;
			exp_q   <= exp_d;
			taken_q <= taken_d;
		end
	end

	assign idle = !pending;

endmodule

### sv/u8u16_fifo.sv
`timescale 1ns / 1ps

module u8u16_fifo import u8u16_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	input  logic rd_en,
	output job_t head,
	output logic head_valid,
	output logic full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// job storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CW'(DEPTH));

endmodule

### sv/u8u16_back.sv
`timescale 1ns / 1ps

module u8u16_back import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        head,
	input  logic        head_valid,
	output logic        pop_job,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] code_unit,
	output logic        run_last,
	output logic        text_done,
	output logic        second
);

	logic        out_valid_q, out_valid_d;
	logic [15:0] unit_q, unit_d;
	logic        last_q, last_d;
	logic        done_q, done_d;
	logic        second_q, second_d;
	logic        load;

	// output register refills whenever it is free or being taken
	assign load = !out_valid_q || pop;

	// pick the next unit from the head job
	always_comb begin
		pop_job     = 1'b0;
		out_valid_d = out_valid_q;
		unit_d      = unit_q;
		last_d      = last_q;
		done_d      = done_q;
		second_d    = second_q;
		if (load) begin
			out_valid_d = head_valid;
			if (head_valid) begin
				if (second_q) begin
					unit_d   = head.unit1;
					last_d   = 1'b1;
					pop_job  = 1'b1;
					second_d = 1'b0;
				end else begin
					unit_d   = head.unit0;
					last_d   = !head.two;
					pop_job  = !head.two;
					second_d = head.two;
				end
				done_d = last_d && head.text_end;
			end
		end
	end

	// output register, control part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			out_valid_q <= out_valid_d;
			second_q    <= second_d;
		end
	end

	// output register, payload part
	always_ff @(posedge clk) begin
		unit_q <= unit_d;
		last_q <= last_d;
		done_q <= done_d;
	end

	assign empty     = !out_valid_q;
	assign code_unit = unit_q;
	assign run_last  = last_q;
	assign text_done = done_q;
	assign second    = second_q;

endmodule

### sv/utf8_to_utf16_transcoder.sv
// a byte's first unit passes through the job queue and then the output register
// throughput: one byte per cycle while full is low; a surrogate pair holds the
// output register for both of its units, absorbed by a queue of QUEUE_DEPTH jobs
// reset: arst_n clears the decoder state, the job queue and the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        text_end,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] code_unit,
	output logic        run_last,
	output logic        text_done
);

	logic accept;
	job_t job;
	logic job_valid;
	logic front_idle;
	job_t head;
	logic head_valid;
	logic pop_job;
	logic back_second;
	logic out_pop;

	assign accept  = push && !full;
	assign out_pop = pop && !empty;

	// decoder front
	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.text_end  (text_end),
		.job       (job),
		.job_valid (job_valid),
		.idle      (front_idle)
	);

	// job queue
	u8u16_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && job_valid),
		.wr_job     (job),
		.rd_en      (pop_job),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	// unit emitter
	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop_job    (pop_job),
		.pop        (out_pop),
		.empty      (empty),
		.code_unit  (code_unit),
		.run_last   (run_last),
		.text_done  (text_done),
		.second     (back_second)
	);

	// checks
	`ASSERT_NEXT(a_end_flushes, clk, arst_n, accept && text_end, front_idle)
	`ASSERT_SAME(a_done_is_last, clk, arst_n, !empty && text_done, run_last)
	`ASSERT_SAME(a_pair_held, clk, arst_n, back_second, head_valid && head.two)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench import u8u16_pkg::*;;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_CYCLES  = 100;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	// one expected utf-16 code unit with its end flags
	typedef struct packed {
		logic [15:0] code;
		logic        byte_last;
		logic        text_last;
	} unit_exp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  in_byte;
	logic        text_end;
	logic        pop;
	logic        empty;
	logic [15:0] code_unit;
	logic        run_last;
	logic        text_done;

	// decoder state mirrored by the predictor
	logic [20:0] pend_val;
	lead_len_t   pend_len;
	logic [2:0]  pend_taken;

	unit_exp_t expected_units[$];

	bit idle_on;
	bit hold_output;
	int mismatches;
	int bytes_sent;
	int units_seen;
	int pairs_seen;
	int fffd_seen;
	int full_stalls;
	int cycles;

	utf8_to_utf16_transcoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.text_end  (text_end),
		.pop       (pop),
		.empty     (empty),
		.code_unit (code_unit),
		.run_last  (run_last),
		.text_done (text_done)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// decode one accepted byte and queue the code units it yields
	task automatic predict_byte(input logic [7:0] b, input logic eot);
		logic [15:0] codes[$];
		logic [20:0] cp;
		logic [20:0] off;
		bit          relead;
		bit          bad;
		unit_exp_t   e;
		relead = 1'b1;
		if (pend_len != LEN_BAD) begin
			if (b[7:6] == 2'b10) begin
				relead = 1'b0;
				pend_val = {pend_val[14:0], b[5:0]};
				pend_taken = pend_taken + 3'd1;
				if (pend_taken >= 3'(pend_len)) begin
					cp = pend_val;
					bad = (pend_len == LEN_TWO && cp < MIN_TWO) ||
						(pend_len == LEN_THREE && cp < MIN_THREE) ||
						(pend_len == LEN_FOUR && cp < SUPP_BASE) ||
						(cp >= SURR_FIRST && cp <= SURR_LAST) || cp > MAX_CP;
					if (bad) begin
						codes.insert(codes.size(), REPLACEMENT);
					end else if (cp < SUPP_BASE) begin
						codes.insert(codes.size(), cp[15:0]);
					end else begin
						off = cp - SUPP_BASE;
						codes.insert(codes.size(), HI_SURR_BASE + 16'(off[19:10]));
						codes.insert(codes.size(), LO_SURR_BASE + 16'(off[9:0]));
					end
					pend_len = LEN_BAD;
				end else if (eot) begin
					codes.insert(codes.size(), REPLACEMENT);
					pend_len = LEN_BAD;
				end
			end else begin
				// broken sequence, the byte is decoded again as a lead
				codes.insert(codes.size(), REPLACEMENT);
				pend_len = LEN_BAD;
			end
		end
		if (relead) begin
			pend_taken = 3'd1;
			casez (b)
				8'b0???????: codes.insert(codes.size(), {8'h00, b});
				8'b110?????: begin
					pend_len = LEN_TWO;
					pend_val = 21'(b[4:0]);
				end
				8'b1110????: begin
					pend_len = LEN_THREE;
					pend_val = 21'(b[3:0]);
				end
				8'b11110???: begin
					pend_len = LEN_FOUR;
					pend_val = 21'(b[2:0]);
				end
				default: codes.insert(codes.size(), REPLACEMENT);
			endcase
			// lead byte on the last byte of a text
			if (pend_len != LEN_BAD && eot) begin
				codes.insert(codes.size(), REPLACEMENT);
				pend_len = LEN_BAD;
			end
		end
		foreach (codes[i]) begin
			e.code = codes[i];
			e.byte_last = (i == codes.size() - 1);
			e.text_last = e.byte_last && eot;
			expected_units.insert(expected_units.size(), e);
		end
	endtask

	// offer one item, optionally after an idle burst
	task automatic send_byte(input logic [7:0] b, input logic eot);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		text_end <= eot;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		predict_byte(b, eot);
		bytes_sent++;
		@(negedge clk);
	endtask

	// encode a code point in a given length and send the first keep bytes
	task automatic send_seq(input logic [20:0] cp, input lead_len_t len, input int keep,
			input logic eot);
		logic [7:0] seq[4];
		case (len)
			LEN_ONE: seq[0] = {1'b0, cp[6:0]};
			LEN_TWO: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			LEN_THREE: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++) begin
			send_byte(seq[i], eot && i == keep - 1);
		end
	endtask

	// one random chunk of text: mostly well-formed, some malformed
	task automatic send_random_chunk();
		lead_len_t   len;
		logic [20:0] cp;
		int          kind;
		logic        eot;
		kind = $urandom_range(0, 9);
		len = lead_len_t'($urandom_range(1, 4));
		eot = ($urandom_range(0, 5) == 0);
		case (len)
			LEN_ONE:   cp = 21'($urandom_range(0, 'h7F));
			LEN_TWO:   cp = 21'($urandom_range('h80, 'h7FF));
			LEN_THREE: cp = 21'($urandom_range('h800, 'hFFFF));
			default:   cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		if (kind <= 5) begin
			send_seq(cp, len, int'(len), eot);
		end else if (kind == 6) begin
			// complete form with arbitrary payload bits
			if (len == LEN_ONE)
				len = LEN_FOUR;
			send_seq(21'($urandom()), len, int'(len), eot);
		end else if (kind == 7) begin
			// cut short, then followed by whatever comes next
			if (len == LEN_ONE)
				len = LEN_THREE;
			send_seq(cp, len, $urandom_range(1, int'(len) - 1), eot);
		end else begin
			send_byte(8'($urandom()), eot);
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_units
		unit_exp_t want;
		if (arst_n && pop && !empty) begin
			units_seen++;
			if (code_unit == REPLACEMENT)
				fffd_seen++;
			if (code_unit >= HI_SURR_BASE && code_unit < LO_SURR_BASE)
				pairs_seen++;
			if (expected_units.size() == 0) begin
				$error("unexpected item: code_unit %h", code_unit);
				mismatches++;
			end else begin
				want = expected_units.pop_front();
				if (code_unit !== want.code) begin
					$error("code_unit: expected %h, got %h", want.code, code_unit);
					mismatches++;
				end
				if (run_last !== want.byte_last) begin
					$error("run_last: expected %b, got %b", want.byte_last, run_last);
					mismatches++;
				end
				if (text_done !== want.text_last) begin
					$error("text_done: expected %b, got %b", want.text_last, text_done);
					mismatches++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_output) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end else begin
				pop <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// ascii limits, the smallest two-byte form and the largest three- and four-byte forms
	task automatic test_well_formed_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_seq(21'h000080, LEN_TWO, 2, 1'b0);
		send_seq(21'h00FFFF, LEN_THREE, 3, 1'b0);
		send_seq(21'h10FFFF, LEN_FOUR, 4, 1'b1);
	endtask

	// each kind of malformed input
	task automatic test_malformed_input();
		// stray continuation and a byte that is never a lead
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		// two-byte lead broken by ascii
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		// overlong, surrogate, above the last code point
		send_seq(21'h00007F, LEN_TWO, 2, 1'b0);
		send_seq(21'h00D800, LEN_THREE, 3, 1'b0);
		send_seq(21'h110000, LEN_FOUR, 4, 1'b0);
		// broken by a four-byte lead that ends the text
		send_seq(21'h0020AC, LEN_THREE, 2, 1'b0);
		send_byte(8'hF0, 1'b1);
		// text ends on a continuation with the sequence unfinished
		send_seq(21'h0020AC, LEN_THREE, 2, 1'b1);
	endtask

	// random text with idle bursts on both sides
	task automatic test_random_text(input int nbytes);
		int stop_at;
		stop_at = bytes_sent + nbytes;
		idle_on = 1'b1;
		while (bytes_sent < stop_at)
			send_random_chunk();
	endtask

	// receiver holds off while surrogate pairs keep coming
	task automatic test_output_backpressure();
		idle_on = 1'b0;
		hold_output = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_seq(21'($urandom_range('h10000, 'h10FFFF)), LEN_FOUR, 4, i == 11);
		end
	endtask

	// back-to-back items with no idling at all
	task automatic test_full_rate_stream(input int nbytes);
		int stop_at;
		stop_at = bytes_sent + nbytes;
		idle_on = 1'b0;
		while (bytes_sent < stop_at)
			send_random_chunk();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_byte = 8'h00;
		text_end = 1'b0;
		pend_val = '0;
		pend_len = LEN_BAD;
		pend_taken = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_well_formed_extremes();
		test_malformed_input();
		test_random_text(400);
		test_output_backpressure();
		test_full_rate_stream(100);

		push <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes, checked %0d code units (%0d surrogate pairs, %0d U+FFFD)",
			bytes_sent, units_seen, pairs_seen, fffd_seen);
		$display("input held off by full on %0d cycles", full_stalls);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
